[sv/tlwc_pkg.sv]
`default_nettype none
package tlwc_pkg;

  localparam int TLWC_DATA_W   = 64;
  localparam int TLWC_VCNT_W   = 4;
  localparam int TLWC_TOTAL_W  = 40;
  localparam int TLWC_NUM_CNT  = 4;

  localparam int CNT_LINE = 0;
  localparam int CNT_WORD = 1;
  localparam int CNT_CHAR = 2;
  localparam int CNT_BYTE = 3;

  localparam logic [7:0] BYTE_NL        = 8'h0A;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] UTF8_TOP_MASK  = 8'hC0;
  localparam logic [7:0] UTF8_CONT_TAG  = 8'h80;

  typedef struct packed {
    logic vld;
    logic nl;
    logic chr;
    logic ws;
  } tlwc_lane_t;

endpackage
`default_nettype wire

[sv/tlwc_if.sv]
`default_nettype none
interface tlwc_in_if;
  logic                               valid;
  logic                               ready;
  logic [tlwc_pkg::TLWC_DATA_W-1:0]  data_bytes;
  logic [tlwc_pkg::TLWC_VCNT_W-1:0]  valid_count;
  logic                               end_of_file;

  modport source (output valid, output data_bytes, output valid_count, output end_of_file,
                  input ready);
  modport sink (input valid, input data_bytes, input valid_count, input end_of_file,
                output ready);
endinterface

interface tlwc_out_if;
  logic                               valid;
  logic                               ready;
  logic [tlwc_pkg::TLWC_TOTAL_W-1:0] line_total;
  logic [tlwc_pkg::TLWC_TOTAL_W-1:0] word_total;
  logic [tlwc_pkg::TLWC_TOTAL_W-1:0] char_total;
  logic [tlwc_pkg::TLWC_TOTAL_W-1:0] byte_total;
  logic                               saturated;

  modport source (output valid, output line_total, output word_total, output char_total,
                  output byte_total, output saturated, input ready);
  modport sink (input valid, input line_total, input word_total, input char_total,
                input byte_total, input saturated, output ready);
endinterface
`default_nettype wire

[sv/tlwc_lane.sv]
`default_nettype none
module tlwc_lane (
  input  wire logic [7:0]          byte_in,
  input  wire logic                en,
  output tlwc_pkg::tlwc_lane_t     flags
);
  import tlwc_pkg::*;

  always_comb begin
    flags.vld = en;
    flags.nl  = (byte_in == BYTE_NL);
    flags.chr = ((byte_in & UTF8_TOP_MASK) != UTF8_CONT_TAG);
    flags.ws  = (byte_in == BYTE_SPACE) || (byte_in == BYTE_TAB) ||
                (byte_in == BYTE_CR) || (byte_in == BYTE_NL);
  end
endmodule
`default_nettype wire

[sv/tlwc_merge.sv]
`default_nettype none
module tlwc_merge #(
  parameter int LANES = 8
) (
  input  wire tlwc_pkg::tlwc_lane_t     lanes [LANES],
  input  wire logic                     word_in,
  output logic [$clog2(LANES+1)-1:0]    line_inc,
  output logic [$clog2(LANES+1)-1:0]    word_inc,
  output logic [$clog2(LANES+1)-1:0]    char_inc,
  output logic [$clog2(LANES+1)-1:0]    byte_inc,
  output logic                          word_out
);
  import tlwc_pkg::*;

  localparam int INC_W = $clog2(LANES + 1);

  always_comb begin
    logic iw;
    iw       = word_in;
    line_inc = '0;
    word_inc = '0;
    char_inc = '0;
    byte_inc = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lanes[k].vld) begin
        line_inc = line_inc + INC_W'(lanes[k].nl);
        char_inc = char_inc + INC_W'(lanes[k].chr);
        byte_inc = byte_inc + INC_W'(1'b1);
        word_inc = word_inc + INC_W'(!iw && !lanes[k].ws);
        iw       = !lanes[k].ws;
      end
    end
    word_out = iw;
  end
endmodule
`default_nettype wire

[sv/text_line_word_char_counter_core.sv]
// An end-of-file request is registered in the first stage, and its result then passes into
// the output register. An end-of-file request waits in the first stage while an unaccepted
// result still holds the output register.
// Throughput: one 8-byte word per cycle unless an end-of-file request stalls; the one-bit
// in-word carry via the lane merge and the saturating count adders form the per-word loop.
// Reset: clears the stage and output valid flags, the counts and the in-word flag.
`default_nettype none
module text_line_word_char_counter_core #(
  parameter int LANES      = 8,
  parameter int COUNT_BITS = 40
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tlwc_in_if.sink         in_ch,
  tlwc_out_if.source      out_ch
);
  import tlwc_pkg::*;

  localparam int INC_W  = $clog2(LANES + 1);
  localparam int WIDE_W = (COUNT_BITS > TLWC_TOTAL_W) ? COUNT_BITS : TLWC_TOTAL_W;

  tlwc_lane_t lane_flags [LANES];
  tlwc_lane_t s1_lane_r  [LANES];
  logic       s1_valid_r;
  logic       s1_eof_r;
  logic       s1_go;
  logic       in_rdy;

  logic                  word_r;
  logic                  word_nxt;
  logic [COUNT_BITS-1:0] acc_r   [TLWC_NUM_CNT];
  logic [COUNT_BITS-1:0] acc_nxt [TLWC_NUM_CNT];
  logic [INC_W-1:0]      inc     [TLWC_NUM_CNT];
  logic [TLWC_NUM_CNT-1:0] ovf;
  logic                  sat_r;
  logic                  sat_nxt;

  logic                    out_valid_r;
  logic [TLWC_TOTAL_W-1:0] out_tot_r [TLWC_NUM_CNT];
  logic                    out_sat_r;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    tlwc_lane u_lane (
      .byte_in (in_ch.data_bytes[8*k +: 8]),
      .en      (in_ch.valid_count > TLWC_VCNT_W'(k)),
      .flags   (lane_flags[k])
    );
  end

  assign s1_go  = s1_valid_r && (!s1_eof_r || !out_valid_r || out_ch.ready);
  assign in_rdy = !s1_valid_r || s1_go;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      s1_lane_r <= lane_flags;
      s1_eof_r  <= in_ch.end_of_file;
    end
  end

  tlwc_merge #(.LANES(LANES)) u_merge (
    .lanes    (s1_lane_r),
    .word_in  (word_r),
    .line_inc (inc[CNT_LINE]),
    .word_inc (inc[CNT_WORD]),
    .char_inc (inc[CNT_CHAR]),
    .byte_inc (inc[CNT_BYTE]),
    .word_out (word_nxt)
  );

  for (genvar c = 0; c < TLWC_NUM_CNT; c++) begin : g_acc
    logic [COUNT_BITS:0] sum;
    assign sum        = {1'b0, acc_r[c]} + (COUNT_BITS + 1)'(inc[c]);
    assign ovf[c]     = sum[COUNT_BITS];
    assign acc_nxt[c] = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  end

  assign sat_nxt = sat_r || (|ovf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= 1'b0;
      sat_r  <= 1'b0;
      for (int c = 0; c < TLWC_NUM_CNT; c++) begin
        acc_r[c] <= '0;
      end
    end else if (s1_go) begin
      if (s1_eof_r) begin
        word_r <= 1'b0;
        sat_r  <= 1'b0;
        for (int c = 0; c < TLWC_NUM_CNT; c++) begin
          acc_r[c] <= '0;
        end
      end else begin
        word_r <= word_nxt;
        sat_r  <= sat_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_eof_r) begin
      for (int c = 0; c < TLWC_NUM_CNT; c++) begin
        out_tot_r[c] <= TLWC_TOTAL_W'(WIDE_W'(acc_nxt[c]));
      end
      out_sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_total = out_tot_r[CNT_LINE];
  assign out_ch.word_total = out_tot_r[CNT_WORD];
  assign out_ch.char_total = out_tot_r[CNT_CHAR];
  assign out_ch.byte_total = out_tot_r[CNT_BYTE];
  assign out_ch.saturated  = out_sat_r;
endmodule
`default_nettype wire

[sim/text_line_word_char_counter_core_test.sv]
import tlwc_pkg::*;

typedef struct packed {
  logic [TLWC_TOTAL_W-1:0] line_total;
  logic [TLWC_TOTAL_W-1:0] word_total;
  logic [TLWC_TOTAL_W-1:0] char_total;
  logic [TLWC_TOTAL_W-1:0] byte_total;
  logic                    saturated;
} wc_totals_t;

class wc_tally_board;
  localparam int LANE_COUNT = TLWC_DATA_W / 8;

  bit          in_word;
  logic [63:0] running [TLWC_NUM_CNT];
  bit          overflowed;
  wc_totals_t  pending_totals[$];
  int          failures;
  int          requests;
  int          files;
  int          checked;

  function new();
    clear_file();
    failures = 0;
    requests = 0;
    files = 0;
    checked = 0;
  endfunction

  function void clear_file();
    in_word = 1'b0;
    foreach (running[i]) running[i] = '0;
    overflowed = 1'b0;
  endfunction

  function logic [63:0] sat_sum(logic [63:0] acc_v, logic [63:0] inc);
    logic [63:0] top;
    top = (64'd1 << TLWC_TOTAL_W) - 64'd1;
    if (acc_v > top || inc > top - acc_v) begin
      overflowed = 1'b1;
      return top;
    end
    return acc_v + inc;
  endfunction

  function void note_request(logic [63:0] data, logic [3:0] count, logic eof);
    int          lanes;
    logic [7:0]  b;
    bit          ws;
    logic [63:0] inc [TLWC_NUM_CNT];
    wc_totals_t  t;
    foreach (inc[i]) inc[i] = '0;
    lanes = (count > LANE_COUNT) ? LANE_COUNT : count;
    for (int k = 0; k < lanes; k++) begin
      b = data[8*k +: 8];
      ws = (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_CR) || (b == BYTE_NL);
      if (b == BYTE_NL) inc[CNT_LINE]++;
      if ((b & UTF8_TOP_MASK) != UTF8_CONT_TAG) inc[CNT_CHAR]++;
      if (!in_word && !ws) inc[CNT_WORD]++;
      in_word = !ws;
    end
    inc[CNT_BYTE] = 64'(lanes);
    foreach (running[i]) running[i] = sat_sum(running[i], inc[i]);
    requests++;
    if (eof) begin
      t.line_total = running[CNT_LINE][TLWC_TOTAL_W-1:0];
      t.word_total = running[CNT_WORD][TLWC_TOTAL_W-1:0];
      t.char_total = running[CNT_CHAR][TLWC_TOTAL_W-1:0];
      t.byte_total = running[CNT_BYTE][TLWC_TOTAL_W-1:0];
      t.saturated = overflowed;
      pending_totals = {pending_totals, t};
      files++;
      clear_file();
    end
  endfunction

  function void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_totals(logic [TLWC_TOTAL_W-1:0] lines, logic [TLWC_TOTAL_W-1:0] words,
                             logic [TLWC_TOTAL_W-1:0] chars, logic [TLWC_TOTAL_W-1:0] bytes,
                             logic sat);
    wc_totals_t want;
    if (pending_totals.size() == 0) begin
      failures++;
      $display("%0t: result with no file pending, expected none, actual %0d %0d %0d %0d %0d",
               $time, lines, words, chars, bytes, sat);
      return;
    end
    want = pending_totals.pop_front();
    checked++;
    compare_field("line_total", want.line_total, lines);
    compare_field("word_total", want.word_total, words);
    compare_field("char_total", want.char_total, chars);
    compare_field("byte_total", want.byte_total, bytes);
    compare_field("saturated", want.saturated, sat);
  endfunction

  function void report_leftovers();
    foreach (pending_totals[i]) begin
      failures++;
      $display("%0t: missing result, expected %0d %0d %0d %0d %0d, actual none", $time,
               pending_totals[i].line_total, pending_totals[i].word_total,
               pending_totals[i].char_total, pending_totals[i].byte_total,
               pending_totals[i].saturated);
    end
  endfunction
endclass

module text_line_word_char_counter_core_test;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 36;
  int   recv_idle_pct = 83;
  int   rx_hold_req = 0;
  int   words_sent = 0;
  int   quiet_cycles;

  wc_tally_board board;

  tlwc_in_if  in_bus ();
  tlwc_out_if res_bus ();

  text_line_word_char_counter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (res_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      board.note_request(in_bus.data_bytes, in_bus.valid_count, in_bus.end_of_file);
    if (rst_n && res_bus.valid && res_bus.ready)
      board.check_totals(res_bus.line_total, res_bus.word_total, res_bus.char_total,
                         res_bus.byte_total, res_bus.saturated);
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("text_line_word_char_counter_core_test NOT OK");
    $finish;
  end

  function automatic logic [63:0] pack_text(string s);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < s.len() && k < 8; k++) w[8*k +: 8] = s[k];
    return w;
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(11))
      0, 1: return BYTE_SPACE;
      2: return BYTE_NL;
      3: return BYTE_TAB;
      4: return BYTE_CR;
      5: return UTF8_CONT_TAG | 8'($urandom_range(63));
      6: return UTF8_TOP_MASK | 8'($urandom_range(63));
      7: return 8'($urandom_range(255));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic logic [63:0] text_word();
    logic [63:0] w;
    if ($urandom_range(7) == 0) return {$urandom, $urandom};
    for (int k = 0; k < 8; k++) w[8*k +: 8] = text_byte();
    return w;
  endfunction

  function automatic logic [3:0] text_count();
    return ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd8;
  endfunction

  task automatic send_word(logic [63:0] data, logic [3:0] count, logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_bytes <= data;
    in_bus.valid_count <= count;
    in_bus.end_of_file <= eof;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_file(int n_words);
    for (int i = 0; i < n_words; i++) send_word(text_word(), text_count(), i == n_words - 1);
  endtask

  task automatic run_random(int n_items);
    int goal;
    goal = words_sent + n_items;
    while (words_sent < goal)
      send_file(($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1));
  endtask

  task automatic wait_results_done();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_totals.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    in_bus.valid <= 1'b0;
    in_bus.data_bytes <= '0;
    in_bus.valid_count <= '0;
    in_bus.end_of_file <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd15, 1'b1);
    send_word(pack_text("hello wo"), 4'd8, 1'b0);
    send_word(pack_text("rld\n"), 4'd4, 1'b0);
    send_word({$urandom, $urandom}, 4'd0, 1'b1);
    send_word({BYTE_NL, BYTE_CR, BYTE_TAB, BYTE_SPACE, BYTE_NL, BYTE_CR, BYTE_TAB, BYTE_SPACE},
              4'd8, 1'b1);
    send_word(64'hBFA9_C3E2_8280_A9C3, 4'd9, 1'b1);
    // Non-blank bytes above the valid count must not end the blank run.
    send_word(64'h4141_4141_4141_2020, 4'd2, 1'b0);
    send_word(pack_text("x"), 4'd1, 1'b1);
    send_word(pack_text("aaaaaaaa"), 4'd8, 1'b0);
    send_word(pack_text("bbbb"), 4'd4, 1'b1);
    send_word(pack_text("ab"), 4'd2, 1'b0);
    send_word({$urandom, $urandom}, 4'd0, 1'b0);
    send_word(pack_text("cd"), 4'd2, 1'b1);
    send_word(64'h0A0A_0A0A_0A0A_0A0A, 4'd12, 1'b1);
    send_word(pack_text("abc"), 4'd3, 1'b1);
    send_word(pack_text("def"), 4'd3, 1'b1);
    send_word(text_word(), 4'd5, 1'b1);
    send_word(text_word(), 4'd6, 1'b1);
    send_word(text_word(), 4'd7, 1'b1);
    wait_results_done();

    run_random(150);
    rx_hold_req = LONG_HOLD;
    for (int i = 0; i < 24; i++) send_word(text_word(), text_count(), 1'b1);
    run_random(150);
    wait_results_done();

    send_idle_pct = 83;
    recv_idle_pct = 36;
    run_random(300);
    wait_results_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);
    wait_results_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    board.report_leftovers();
    $display("Checked %0d file results from %0d requests, covering empty files,", board.checked,
             board.requests);
    $display("oversized byte counts, multibyte text and a long result stall.");
    if (board.failures == 0) begin
      $display("text_line_word_char_counter_core_test OK");
    end else begin
      $display("text_line_word_char_counter_core_test NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
sv/tlwc_pkg.sv
sv/tlwc_if.sv
sv/tlwc_lane.sv
sv/tlwc_merge.sv
sv/text_line_word_char_counter_core.sv
sim/text_line_word_char_counter_core_test.sv
